// ===== design/sorted_key_binary_search_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Sorted key search unit - assertion macros
// Shared property forms used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_BINARY_SEARCH_UNIT_DEFINES_SVH
`define SORTED_KEY_BINARY_SEARCH_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SKBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define SKBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/skbs_pkg.sv =====
// ----------------------------------------------------------------------------
// skbs_pkg
// Widths, defaults and register codes for the sorted key search unit.
// ----------------------------------------------------------------------------
package skbs_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_KEY_BYTES   = 13;

  localparam int SLOT_W      = 8;
  localparam int HEAD_W      = 64;
  localparam int TAIL_PORT_W = 40;
  localparam int CNT_W       = 9;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Word index of a register, taken from paddr[APB_AW-1].
  typedef enum logic {
    REG_ENTRY_COUNT = 1'b0,
    REG_NONE        = 1'b1
  } reg_idx_t;

endpackage

// ===== design/skbs_key_ram.sv =====
// ----------------------------------------------------------------------------
// skbs_key_ram
// Key storage: one write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module skbs_key_ram
  import skbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES,
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int TW = 8 * (KEY_BYTES - 8)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [AW-1:0]     wr_addr,
  input  logic [HEAD_W-1:0] wr_head,
  input  logic [TW-1:0]     wr_tail,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  output logic [HEAD_W-1:0] rd_head,
  output logic [TW-1:0]     rd_tail
);

  logic [HEAD_W-1:0] head_store [TABLE_DEPTH];
  logic [TW-1:0]     tail_store [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      head_store[wr_addr] <= wr_head;
      tail_store[wr_addr] <= wr_tail;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_head <= head_store[rd_addr];
      rd_tail <= tail_store[rd_addr];
    end
  end

endmodule

// ===== design/sorted_key_binary_search_unit.sv =====
// ----------------------------------------------------------------------------
// sorted_key_binary_search_unit
// Table of sorted keys with a halving search over the loaded entries.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): in_func 0 stores in_key_head/in_key_tail
//   at in_slot and gives no result; in_func 1 looks the key up among the first
//   entry_count entries. Result channel (out_valid/out_ready) carries
//   out_found and out_match_index (0 when not found).
//   Register entry_count sits at byte address 0 of the APB port; write it only
//   while no lookup is in flight. pready is tied high.
// Timing:
//   A lookup makes one key RAM read and compare per halving step, so it needs
//   up to ceil(log2(count+1)) steps (9 for 256 entries). The next item is
//   taken once the result sits in the output register: the single RAM read
//   port serves one lookup at a time, so a new item waits for the last to end.
// Reset:
//   rst_n clears entry_count, the controller and out_valid. Key RAM contents
//   are not cleared; read only entries that were written.
// Stall:
//   A finished result holds in the output register until out_ready; a new
//   item may be accepted meanwhile, and the next result waits for the slot.
// ----------------------------------------------------------------------------
module sorted_key_binary_search_unit
  import skbs_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input channel
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   in_func,
  input  logic [SLOT_W-1:0]      in_slot,
  input  logic [HEAD_W-1:0]      in_key_head,
  input  logic [TAIL_PORT_W-1:0] in_key_tail,
  // result channel
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   out_found,
  output logic [SLOT_W-1:0]      out_match_index,
  // configuration
  input  logic                   psel,
  input  logic                   penable,
  input  logic                   pwrite,
  input  logic [APB_AW-1:0]      paddr,
  input  logic [APB_DW-1:0]      pwdata,
  output logic [APB_DW-1:0]      prdata,
  output logic                   pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int TW = 8 * (KEY_BYTES - 8);
  localparam int KW = HEAD_W + TW;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SRCH,
    S_DONE
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  entry_count_r, entry_count_nxt;
  logic [HEAD_W-1:0] key_head_r, key_head_nxt;
  logic [TW-1:0]     key_tail_r, key_tail_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [AW-1:0]     mid_r, mid_nxt;
  logic              res_found_r, res_found_nxt;
  logic [SLOT_W-1:0] res_index_r, res_index_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_found_r, out_found_nxt;
  logic [SLOT_W-1:0] out_index_r, out_index_nxt;

  logic              in_acc;
  logic              cfg_wr;
  logic [31:0]       count32;
  logic [CW-1:0]     count;
  logic [31:0]       mid_ext;
  logic [31:0]       slot_ext;
  logic              slot_ok;

  logic [HEAD_W-1:0] rd_head;
  logic [TW-1:0]     rd_tail;
  logic [KW-1:0]     rd_key;
  logic [KW-1:0]     key_r;
  logic              key_gt;
  logic              key_eq;
  logic [CW-1:0]     lo_step;
  logic [CW-1:0]     hi_step;
  logic [CW-1:0]     lo_sel;
  logic [CW-1:0]     hi_sel;
  logic [CW:0]       mid_sum;
  logic [AW-1:0]     rd_addr;
  logic              rd_en;
  logic              wr_en;

  // --------------------------------------------------------------------------
  // Configuration port
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready
                  && (paddr[APB_AW-1] == REG_ENTRY_COUNT);
  assign prdata = (paddr[APB_AW-1] == REG_ENTRY_COUNT) ? APB_DW'(entry_count_r) : '0;

  always_comb begin
    entry_count_nxt = entry_count_r;
    if (cfg_wr) begin
      entry_count_nxt = pwdata[CNT_W-1:0];
    end
  end

  // --------------------------------------------------------------------------
  // Search datapath
  // --------------------------------------------------------------------------
  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;

  // saturate the count to the table depth
  assign count32 = (32'(entry_count_r) > 32'(TABLE_DEPTH)) ? 32'(TABLE_DEPTH)
                                                           : 32'(entry_count_r);
  assign count   = count32[CW-1:0];

  assign slot_ext = 32'(in_slot);
  assign slot_ok  = (slot_ext < 32'(TABLE_DEPTH));
  assign wr_en    = in_acc && !in_func && slot_ok;

  assign rd_key = {rd_head, rd_tail};
  assign key_r  = {key_head_r, key_tail_r};
  assign key_gt = (key_r > rd_key);
  assign key_eq = (key_r == rd_key);

  // hi is exclusive: the live range is [lo, hi)
  assign lo_step = key_gt ? (CW'(mid_r) + CW'(1)) : lo_r;
  assign hi_step = (key_gt || key_eq) ? hi_r : CW'(mid_r);

  always_comb begin
    if (state_r == S_SRCH) begin
      lo_sel = lo_step;
      hi_sel = hi_step;
    end else begin
      lo_sel = '0;
      hi_sel = count;
    end
  end

  assign mid_sum = {1'b0, lo_sel} + {1'b0, hi_sel} - (CW+1)'(1);
  assign rd_addr = mid_sum[AW:1];

  assign rd_en = (in_acc && in_func && (count != '0))
                 || ((state_r == S_SRCH) && !key_eq && (lo_step < hi_step));

  assign mid_ext = 32'(mid_r);

  skbs_key_ram #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_key_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (slot_ext[AW-1:0]),
    .wr_head (in_key_head),
    .wr_tail (in_key_tail[TW-1:0]),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_head (rd_head),
    .rd_tail (rd_tail)
  );

  // --------------------------------------------------------------------------
  // Controller
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    key_head_nxt  = key_head_r;
    key_tail_nxt  = key_tail_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    res_found_nxt = res_found_r;
    res_index_nxt = res_index_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;

    // drop the result once the receiver takes it
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc && in_func) begin
          key_head_nxt  = in_key_head;
          key_tail_nxt  = in_key_tail[TW-1:0];
          lo_nxt        = '0;
          hi_nxt        = count;
          mid_nxt       = rd_addr;
          res_found_nxt = 1'b0;
          res_index_nxt = '0;
          state_nxt     = (count == '0) ? S_DONE : S_SRCH;
        end
      end
      S_SRCH: begin
        if (key_eq) begin
          res_found_nxt = 1'b1;
          res_index_nxt = mid_ext[SLOT_W-1:0];
          state_nxt     = S_DONE;
        end else if (lo_step >= hi_step) begin
          res_found_nxt = 1'b0;
          res_index_nxt = '0;
          state_nxt     = S_DONE;
        end else begin
          lo_nxt  = lo_step;
          hi_nxt  = hi_step;
          mid_nxt = rd_addr;
        end
      end
      S_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_index_nxt = res_index_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      entry_count_r <= '0;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      entry_count_r <= entry_count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_head_r  <= key_head_nxt;
    key_tail_r  <= key_tail_nxt;
    lo_r        <= lo_nxt;
    hi_r        <= hi_nxt;
    mid_r       <= mid_nxt;
    res_found_r <= res_found_nxt;
    res_index_r <= res_index_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_match_index = out_index_r;

endmodule

// ===== design/skbs_checker.sv =====
// ----------------------------------------------------------------------------
// skbs_checker
// Port-level checks of the sorted key search unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "sorted_key_binary_search_unit_defines.svh"

module skbs_checker
  import skbs_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_valid,
  input logic                   in_ready,
  input logic                   in_func,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic                   out_found,
  input logic [SLOT_W-1:0]      out_match_index
);

  // a stalled result must hold
  `SKBS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_found) && $stable(out_match_index), "result changed while stalled")

  // a miss always reports index zero
  `SKBS_ASSERT_NOW(a_miss_index, out_valid && !out_found, out_match_index == '0, "miss with nonzero index")

  // a lookup's result does not rise at the edge that accepts it
  `SKBS_ASSERT_NEXT(a_min_latency, in_valid && in_ready && in_func, !$rose(out_valid), "result rose one cycle after lookup")

  // a search in flight blocks the input for the following cycle
  `SKBS_ASSERT_NEXT(a_busy_after_lookup, in_valid && in_ready && in_func, !in_ready, "input ready during search")

endmodule

bind sorted_key_binary_search_unit skbs_checker u_skbs_checker (.*);
